// File: rtl/psc_pkg.sv
// Shared constants, types and helpers for the per-second counter ring.
package psc_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int CFG_W     = 7;
  localparam int LAG_W     = 6;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CLAMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int CMP_W     = (LAG_W > CNT_W) ? LAG_W : CNT_W;
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(8);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_GET   = 2'd1,
    KIND_DELTA = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    data_t             timestamp;
    data_t             sample;
    logic [LAG_W-1:0]  lag;
  } item_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr;
    logic  wr_en;
    slot_t wr_addr;
    data_t wr_data;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CARRY_RD,
    ST_FILL,
    ST_ACT,
    ST_CUR_WAIT,
    ST_BACK_WAIT,
    ST_EMIT
  } state_t;

  // Active slot count: the register value clamped to [2, MAX_SLOTS].
  function automatic cnt_t active_count(logic [CFG_W-1:0] cfg);
    logic [CLAMP_W-1:0] v;
    v = CLAMP_W'(cfg);
    if (v < CLAMP_W'(2)) begin
      v = CLAMP_W'(2);
    end else if (v > CLAMP_W'(MAX_SLOTS)) begin
      v = CLAMP_W'(MAX_SLOTS);
    end
    return CNT_W'(v);
  endfunction

endpackage

// File: rtl/psc_if.sv
// Valid/ready channel interfaces for input items and results.
interface psc_item_if;
  logic                            valid;
  logic                            ready;
  logic [psc_pkg::KIND_W-1:0]      kind;
  logic [psc_pkg::DATA_W-1:0]      timestamp;
  logic [psc_pkg::DATA_W-1:0]      sample;
  logic [psc_pkg::LAG_W-1:0]       lag;

  modport source (output valid, kind, timestamp, sample, lag, input ready);
  modport sink   (input valid, kind, timestamp, sample, lag, output ready);
endinterface

interface psc_result_if;
  logic                        valid;
  logic                        ready;
  logic [psc_pkg::DATA_W-1:0]  reading;

  modport source (output valid, reading, input ready);
  modport sink   (input valid, reading, output ready);
endinterface

// File: rtl/per_second_counter_ring.sv
// Top level of the per-second counter ring: configuration register and wiring.
// A forward stamp adds a carry read and gap filling of min(gap, n) slots after the
// 32-step remainder unit. Unused kinds and over-long delta lags skip the remainder unit.
// One item is in work at a time; its result waits in an output register.
// Reset is synchronous: slot valid flags clear so every slot reads zero,
// the last stamp becomes zero and the slot count returns to eight.
module per_second_counter_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  psc_item_if.sink                    in_item,
  psc_result_if.source                out_res,
  input  logic                        cfg_we,
  input  logic [psc_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [psc_pkg::CFG_W-1:0]  slots_r;
  psc_pkg::cnt_t              n_in;
  psc_pkg::item_t             item;
  logic                       mod_start;
  psc_pkg::data_t             mod_dividend_b;
  psc_pkg::cnt_t              mod_divisor;
  logic                       mod_done;
  psc_pkg::slot_t             mod_rem_a;
  psc_pkg::slot_t             mod_rem_b;
  psc_pkg::ram_req_t          ram_req;
  psc_pkg::data_t             ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= psc_pkg::SLOTS_RESET;
    end else if (cfg_we) begin
      slots_r <= cfg_wdata;
    end
  end

  assign n_in = psc_pkg::active_count(slots_r);

  always_comb begin
    item.kind      = psc_pkg::kind_t'(in_item.kind);
    item.timestamp = in_item.timestamp;
    item.sample    = in_item.sample;
    item.lag       = in_item.lag;
  end

  psc_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_item.valid),
    .in_ready       (in_item.ready),
    .in_item        (item),
    .n_in           (n_in),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_reading    (out_res.reading),
    .mod_start      (mod_start),
    .mod_dividend_b (mod_dividend_b),
    .mod_divisor    (mod_divisor),
    .mod_done       (mod_done),
    .mod_rem_a      (mod_rem_a),
    .mod_rem_b      (mod_rem_b),
    .ram_req        (ram_req),
    .ram_rd_data    (ram_rd_data)
  );

  psc_mod u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mod_start),
    .dividend_a (in_item.timestamp),
    .dividend_b (mod_dividend_b),
    .divisor    (mod_divisor),
    .done       (mod_done),
    .rem_a      (mod_rem_a),
    .rem_b      (mod_rem_b)
  );

  psc_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

// File: rtl/psc_mod.sv
// Two-lane restoring remainder unit, one dividend bit per cycle.
module psc_mod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  psc_pkg::data_t        dividend_a,
  input  psc_pkg::data_t        dividend_b,
  input  psc_pkg::cnt_t         divisor,
  output logic                  done,
  output psc_pkg::slot_t        rem_a,
  output psc_pkg::slot_t        rem_b
);

  psc_pkg::data_t                 quo_a_r;
  psc_pkg::data_t                 quo_b_r;
  psc_pkg::cnt_t                  rem_a_r;
  psc_pkg::cnt_t                  rem_b_r;
  logic [psc_pkg::STEP_W-1:0]     cnt_r;
  logic                           run_r;
  logic                           done_r;
  psc_pkg::cnt_t                  rem_a_nxt;
  psc_pkg::cnt_t                  rem_b_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic psc_pkg::cnt_t step(psc_pkg::cnt_t rem, logic bit_in,
                                         psc_pkg::cnt_t d);
    logic [psc_pkg::CNT_W:0] sh;
    sh = {rem, bit_in};
    if (sh >= {1'b0, d}) begin
      sh = sh - {1'b0, d};
    end
    return sh[psc_pkg::CNT_W-1:0];
  endfunction

  always_comb begin
    rem_a_nxt = step(rem_a_r, quo_a_r[psc_pkg::DATA_W-1], divisor);
    rem_b_nxt = step(rem_b_r, quo_b_r[psc_pkg::DATA_W-1], divisor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= psc_pkg::STEP_W'(psc_pkg::DIV_STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - psc_pkg::STEP_W'(1);
        if (cnt_r == psc_pkg::STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_a_r <= dividend_a;
      quo_b_r <= dividend_b;
      rem_a_r <= '0;
      rem_b_r <= '0;
    end else if (run_r) begin
      quo_a_r <= {quo_a_r[psc_pkg::DATA_W-2:0], 1'b0};
      quo_b_r <= {quo_b_r[psc_pkg::DATA_W-2:0], 1'b0};
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
    end
  end

  // The remainder is below the divisor, so it fits a slot index.
  assign done  = done_r;
  assign rem_a = rem_a_r[psc_pkg::SLOT_W-1:0];
  assign rem_b = rem_b_r[psc_pkg::SLOT_W-1:0];

endmodule

// File: rtl/psc_ram.sv
// Slot memory with registered read and per-slot valid flags cleared at reset.
module psc_ram (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_pkg::ram_req_t  req,
  output psc_pkg::data_t     rd_data
);

  psc_pkg::data_t                 mem [psc_pkg::MAX_SLOTS];
  logic [psc_pkg::MAX_SLOTS-1:0]  valid_r;
  psc_pkg::data_t                 rd_q_r;
  logic                           rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // A slot never written since reset reads as zero.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: rtl/psc_seq.sv
// Item sequencer: gap fill, slot update and read, result register.
module psc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  psc_pkg::item_t     in_item,
  input  psc_pkg::cnt_t      n_in,
  output logic               out_valid,
  input  logic               out_ready,
  output psc_pkg::data_t     out_reading,
  output logic               mod_start,
  output psc_pkg::data_t     mod_dividend_b,
  output psc_pkg::cnt_t      mod_divisor,
  input  logic               mod_done,
  input  psc_pkg::slot_t     mod_rem_a,
  input  psc_pkg::slot_t     mod_rem_b,
  output psc_pkg::ram_req_t  ram_req,
  input  psc_pkg::data_t     ram_rd_data
);

  localparam int BK_W = psc_pkg::CMP_W + 1;

  psc_pkg::state_t  state_r;
  psc_pkg::state_t  state_nxt;
  psc_pkg::item_t   item_r;
  psc_pkg::cnt_t    n_r;
  psc_pkg::data_t   last_r;
  psc_pkg::slot_t   cur_r;
  psc_pkg::slot_t   pos_r;
  psc_pkg::slot_t   pos_nxt;
  psc_pkg::cnt_t    fill_left_r;
  psc_pkg::cnt_t    fill_count;
  psc_pkg::data_t   cur_val_r;
  psc_pkg::data_t   res_r;
  logic             out_valid_r;
  psc_pkg::data_t   out_reading_r;
  logic             accept;
  logic             lag_big;
  logic             forward;
  logic             out_free;
  psc_pkg::cnt_t    pos_inc;
  psc_pkg::slot_t   back_addr;
  psc_pkg::data_t   gap;
  logic [BK_W-1:0]  back_sum;

  assign accept   = in_valid && in_ready;
  assign lag_big  = (in_item.kind == psc_pkg::KIND_DELTA) &&
                    (psc_pkg::CMP_W'(in_item.lag) >= psc_pkg::CMP_W'(n_in));
  assign forward  = item_r.timestamp > last_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    gap        = item_r.timestamp - last_r;
    fill_count = (gap < psc_pkg::DATA_W'(n_r)) ? psc_pkg::CNT_W'(gap) : n_r;
    pos_inc    = psc_pkg::CNT_W'(pos_r) + psc_pkg::CNT_W'(1);
    pos_nxt    = (pos_inc == n_r) ? '0 : pos_inc[psc_pkg::SLOT_W-1:0];
    // The lag is below the slot count here, so one correction suffices.
    back_sum   = BK_W'(cur_r) + BK_W'(n_r) - BK_W'(item_r.lag);
    if (back_sum >= BK_W'(n_r)) begin
      back_sum = back_sum - BK_W'(n_r);
    end
    back_addr  = back_sum[psc_pkg::SLOT_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.kind == psc_pkg::KIND_NONE) begin
            state_nxt = psc_pkg::ST_IDLE;
          end else if (lag_big) begin
            state_nxt = psc_pkg::ST_EMIT;
          end else begin
            state_nxt = psc_pkg::ST_DIV;
          end
        end
      end
      psc_pkg::ST_DIV: begin
        if (mod_done) begin
          state_nxt = forward ? psc_pkg::ST_CARRY_RD : psc_pkg::ST_ACT;
        end
      end
      psc_pkg::ST_CARRY_RD: state_nxt = psc_pkg::ST_FILL;
      psc_pkg::ST_FILL: begin
        if (fill_left_r == psc_pkg::CNT_W'(1)) begin
          state_nxt = psc_pkg::ST_ACT;
        end
      end
      psc_pkg::ST_ACT: begin
        state_nxt = (item_r.kind == psc_pkg::KIND_PUSH) ? psc_pkg::ST_IDLE
                                                         : psc_pkg::ST_CUR_WAIT;
      end
      psc_pkg::ST_CUR_WAIT: begin
        state_nxt = (item_r.kind == psc_pkg::KIND_DELTA) ? psc_pkg::ST_BACK_WAIT
                                                          : psc_pkg::ST_EMIT;
      end
      psc_pkg::ST_BACK_WAIT: state_nxt = psc_pkg::ST_EMIT;
      psc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = psc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state_r == psc_pkg::ST_IDLE);
    mod_start       = accept && (in_item.kind != psc_pkg::KIND_NONE) && !lag_big;
    ram_req         = '0;
    case (state_r)
      psc_pkg::ST_CARRY_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = pos_r;
      end
      psc_pkg::ST_FILL: begin
        // The carried sample stays in the read register for the whole fill.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = pos_nxt;
        ram_req.wr_data = ram_rd_data;
      end
      psc_pkg::ST_ACT: begin
        if (item_r.kind == psc_pkg::KIND_PUSH) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = cur_r;
          ram_req.wr_data = item_r.sample;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = cur_r;
        end
      end
      psc_pkg::ST_CUR_WAIT: begin
        if (item_r.kind == psc_pkg::KIND_DELTA) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = back_addr;
        end
      end
      default: ram_req = '0;
    endcase
  end

  assign mod_dividend_b = last_r;
  assign mod_divisor    = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psc_pkg::ST_IDLE;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == psc_pkg::ST_DIV && mod_done) begin
        last_r <= item_r.timestamp;
      end
      if (state_r == psc_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      n_r    <= n_in;
      res_r  <= '0;
    end
    case (state_r)
      psc_pkg::ST_DIV: begin
        if (mod_done) begin
          cur_r       <= mod_rem_a;
          pos_r       <= mod_rem_b;
          fill_left_r <= fill_count;
        end
      end
      psc_pkg::ST_FILL: begin
        pos_r       <= pos_nxt;
        fill_left_r <= fill_left_r - psc_pkg::CNT_W'(1);
      end
      psc_pkg::ST_CUR_WAIT: begin
        cur_val_r <= ram_rd_data;
        res_r     <= ram_rd_data;
      end
      psc_pkg::ST_BACK_WAIT: res_r <= cur_val_r - ram_rd_data;
      psc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_reading_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_reading = out_reading_r;

endmodule
